// ----- rtl/core/qrs_pkg.sv -----
// shared types, constants and coefficient table for the qrs beat detector
package qrs_pkg;

    localparam int DEF_WINDOW      = 37;
    localparam int DEF_SAMPLE_BITS = 12;

    localparam int REFR_W  = 10;
    localparam int DECAY_W = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int VAL_W   = 40;
    localparam int TOTAL_W = 46;
    localparam int PROD_W  = 80;

    localparam logic [CFG_IDX_W-1:0] CFG_REFRACTORY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY      = 2'd1;

    localparam logic [REFR_W-1:0]  REFR_RESET   = 10'd63;
    localparam logic [DECAY_W-1:0] DECAY_RESET  = 16'd65503;
    localparam logic [VAL_W-1:0]   THRESH_RESET = 40'd512000;

    // control of the shared multiplier
    typedef struct packed {
        logic en;
        logic hi;
    } t_mul_ctl;

    // biquad coefficients in Q3.29, per section in the order b0, b1, a1, b2, a2
    function automatic logic signed [31:0] qrs_coef(input logic [1:0] sec,
                                                    input logic [2:0] term);
        logic signed [31:0] c;
        c = 32'sd0;
        case ({sec, term})
            5'b00_000: c = 32'sd841282;
            5'b00_001: c = 32'sd1682565;
            5'b00_010: c = -32'sd930699517;
            5'b00_011: c = 32'sd841282;
            5'b00_100: c = 32'sd416439766;
            5'b01_000: c = 32'sd536870912;
            5'b01_001: c = 32'sd0;
            5'b01_010: c = -32'sd922129972;
            5'b01_011: c = -32'sd536870912;
            5'b01_100: c = 32'sd447683923;
            5'b10_000: c = 32'sd536870912;
            5'b10_001: c = -32'sd1073741824;
            5'b10_010: c = -32'sd1029195164;
            5'b10_011: c = 32'sd536870912;
            5'b10_100: c = 32'sd501420100;
            default:   c = 32'sd0;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/core/qrs_ram.sv -----
// generic single-port-write ram with registered read
module qrs_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 37,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/core/qrs_mul.sv -----
// shared 32 x 24 multiplier with accumulate, builds a 32 x 48 product as a low half, then an accumulated high half
module qrs_mul (
    input  logic                      i_clk,
    input  qrs_pkg::t_mul_ctl         i_ctl,
    input  logic [31:0]               i_a,
    input  logic [47:0]               i_b,
    output logic [qrs_pkg::PROD_W-1:0] o_prod
);
    import qrs_pkg::*;

    logic [PROD_W-1:0] r_prod;
    logic [55:0]       part;

    assign part = 56'(i_a) * 56'(i_ctl.hi ? i_b[47:24] : i_b[23:0]);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            if (i_ctl.hi) begin
                r_prod <= r_prod + (PROD_W'(part) << 24);
            end else begin
                r_prod <= PROD_W'(part);
            end
        end
    end

    assign o_prod = r_prod;
endmodule

// ----- rtl/core/qrs_beat_detector.sv -----
// qrs beat detector top level: band-pass, slope square, window mean, adaptive threshold
// the threshold decay step adds the S_DECAY state to the path from input transfer to output valid
// the three biquads take 15 coefficient products in turn on one
// shared multiplier; the window mean takes two reciprocal products on it
// a new sample is taken only in the idle state; input stalls while a sample is in work
// reset (synchronous, active low) clears filter state, window, counters and output valid
module qrs_beat_detector #(
    parameter int WINDOW      = qrs_pkg::DEF_WINDOW,
    parameter int SAMPLE_BITS = qrs_pkg::DEF_SAMPLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [SAMPLE_BITS-1:0]        i_sample,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [qrs_pkg::VAL_W-1:0]     o_integrated,
    output logic [qrs_pkg::VAL_W-1:0]     o_threshold,
    output logic                          o_beat,
    input  logic                          i_cfg_we,
    input  logic [qrs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [qrs_pkg::CFG_W-1:0]     i_cfg_data
);
    import qrs_pkg::*;

    localparam int PW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam logic [22:0] WIN23 = 23'(WINDOW);
    // ceil(2^35 / window): exact quotient for dividends below 2^29
    localparam logic [47:0] RECIP =
        48'(((64'd1 << 35) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
    localparam logic signed [53:0] V48_MAX = 54'sd140737488355327;
    localparam logic signed [53:0] V48_MIN = -54'sd140737488355328;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_FILT  = 11'b000_0000_0010,
        S_CONV  = 11'b000_0000_0100,
        S_DIFF  = 11'b000_0000_1000,
        S_SQ    = 11'b000_0001_0000,
        S_SQR   = 11'b000_0010_0000,
        S_WIN   = 11'b000_0100_0000,
        S_DIV   = 11'b000_1000_0000,
        S_DET   = 11'b001_0000_0000,
        S_DECAY = 11'b010_0000_0000,
        S_DONE  = 11'b100_0000_0000
    } t_state;

    t_state                   r_state;
    logic [1:0]               r_sec;
    logic [2:0]               r_term;
    logic [1:0]               r_ph;
    logic signed [47:0]       r_x;
    logic signed [47:0]       r_y;
    logic signed [47:0]       r_w [6];
    logic signed [53:0]       r_sum;
    logic signed [24:0]       r_prev;
    logic signed [24:0]       r_filt;
    logic [25:0]              r_md;
    logic [VAL_W-1:0]         r_sq;
    logic [TOTAL_W-1:0]       r_total;
    logic [PW-1:0]            r_pos;
    logic [WINDOW-1:0]        r_wvalid;
    logic [TOTAL_W-1:0]       r_dq;
    logic [5:0]               r_rem;
    logic                     r_cnt;
    logic [VAL_W-1:0]         r_mean;
    logic [VAL_W-1:0]         r_thr;
    logic [VAL_W-1:0]         r_thr_out;
    logic                     r_beat;
    logic [REFR_W-1:0]        r_since;
    logic [REFR_W-1:0]        r_refr;
    logic [DECAY_W-1:0]       r_decay;
    logic                     r_ovalid;
    logic [VAL_W-1:0]         r_o_int;
    logic [VAL_W-1:0]         r_o_thr;
    logic                     r_o_beat;

    t_mul_ctl                 mul_ctl;
    logic [31:0]              mul_a;
    logic [47:0]              mul_b;
    logic [PROD_W-1:0]        prod;
    logic [VAL_W-1:0]         ram_q;

    // filter term datapath
    logic signed [31:0]       coef_c;
    logic                     use_y;
    logic signed [47:0]       term_v;
    logic [31:0]              c_mag;
    logic [47:0]              v_mag;
    logic [50:0]              rnd;
    logic signed [53:0]       term_val;
    logic signed [53:0]       base;
    logic signed [53:0]       acc;
    logic signed [47:0]       acc_sat;

    // post-filter datapath
    logic [47:0]              x_mag;
    logic [32:0]              m2;
    logic signed [24:0]       filt_new;
    logic signed [25:0]       diff;
    logic [42:0]              sq_raw;
    logic [VAL_W-1:0]         sq_sat;
    logic [VAL_W-1:0]         old_val;
    logic [TOTAL_W-1:0]       total_new;
    logic [28:0]              div_x;
    logic [22:0]              div_q;
    logic [22:0]              div_r;
    logic [REFR_W-1:0]        since_inc;
    logic                     allowed;
    logic                     det_beat;
    logic [43:0]              thr_mix;

    assign coef_c  = qrs_coef(r_sec, r_term);
    assign use_y   = (r_term == 3'd2) || (r_term == 3'd4);
    assign term_v  = use_y ? r_y : r_x;
    assign c_mag   = coef_c[31] ? 32'(-coef_c) : 32'(coef_c);
    assign v_mag   = term_v[47] ? 48'(-term_v) : 48'(term_v);
    assign rnd     = 51'((prod + (PROD_W'(1) << 28)) >> 29);
    assign term_val = (coef_c[31] ^ term_v[47] ^ use_y) ? -$signed({3'b000, rnd})
                                                         : $signed({3'b000, rnd});

    always_comb begin
        case (r_term)
            3'd0:    base = 54'(r_w[0]);
            3'd1:    base = 54'(r_w[1]);
            3'd3:    base = 54'sd0;
            default: base = r_sum;
        endcase
    end

    assign acc = base + term_val;

    always_comb begin
        if (acc > V48_MAX) begin
            acc_sat = V48_MAX[47:0];
        end else if (acc < V48_MIN) begin
            acc_sat = V48_MIN[47:0];
        end else begin
            acc_sat = acc[47:0];
        end
    end

    // q24.24 to q16.8, half away from zero, saturated to 25 bits
    assign x_mag = r_x[47] ? 48'(-r_x) : 48'(r_x);
    assign m2    = 33'((49'(x_mag) + 49'h8000) >> 16);

    always_comb begin
        if (!r_x[47]) begin
            filt_new = (m2 > 33'h0FF_FFFF) ? 25'sh0FF_FFFF : $signed(m2[24:0]);
        end else begin
            filt_new = (m2 >= 33'h100_0000) ? 25'sh100_0000 : $signed(25'(-m2[24:0]));
        end
    end

    assign diff   = 26'(r_filt) - 26'(r_prev);
    assign sq_raw = 43'((prod[51:0] + 52'd128) >> 8);
    assign sq_sat = (sq_raw > 43'(40'hFF_FFFF_FFFF)) ? 40'hFF_FFFF_FFFF : sq_raw[39:0];

    assign old_val   = r_wvalid[r_pos] ? ram_q : '0;
    assign total_new = r_total - TOTAL_W'(old_val) + TOTAL_W'(r_sq);

    // mean in two halves: upper 23 bits first, then the remainder joined to the lower 23
    assign div_x = r_cnt ? {r_rem, r_dq[22:0]} : 29'(r_dq[TOTAL_W-1:23]);
    assign div_q = prod[57:35];
    assign div_r = r_dq[TOTAL_W-1:23] - 23'(div_q * WIN23);

    assign since_inc = (r_since == {REFR_W{1'b1}}) ? r_since : r_since + 1'b1;
    assign allowed   = since_inc >= r_refr;
    assign det_beat  = allowed && (r_mean > r_thr);
    assign thr_mix   = 44'((44'(r_mean) + 44'(r_thr) * 44'd7) >> 3);

    // shared multiplier operand selection
    always_comb begin
        mul_ctl.en = 1'b0;
        mul_ctl.hi = r_ph[0];
        mul_a      = '0;
        mul_b      = '0;
        case (r_state)
            S_FILT: begin
                mul_ctl.en = (r_ph != 2'd2);
                mul_a      = c_mag;
                mul_b      = v_mag;
            end
            S_SQ: begin
                mul_ctl.en = 1'b1;
                mul_a      = 32'(r_md);
                mul_b      = 48'(r_md);
            end
            S_DIV: begin
                mul_ctl.en = (r_ph != 2'd2);
                mul_a      = 32'(div_x);
                mul_b      = RECIP;
            end
            S_DECAY: begin
                mul_ctl.en = (r_ph != 2'd2);
                mul_a      = 32'(r_decay);
                mul_b      = 48'(r_thr);
            end
            default: begin
                mul_ctl.en = 1'b0;
            end
        endcase
    end

    qrs_mul u_mul (
        .i_clk  (i_clk),
        .i_ctl  (mul_ctl),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    qrs_ram #(
        .WIDTH (VAL_W),
        .DEPTH (WINDOW),
        .AW    (PW)
    ) u_win (
        .i_clk   (i_clk),
        .i_we    (r_state == S_WIN),
        .i_waddr (r_pos),
        .i_wdata (r_sq),
        .i_raddr (r_pos),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_sec    <= '0;
            r_term   <= '0;
            r_ph     <= '0;
            for (int i = 0; i < 6; i++) begin
                r_w[i] <= '0;
            end
            r_prev   <= '0;
            r_total  <= '0;
            r_pos    <= '0;
            r_wvalid <= '0;
            r_thr    <= THRESH_RESET;
            r_since  <= '0;
            r_refr   <= REFR_RESET;
            r_decay  <= DECAY_RESET;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_REFRACTORY) begin
                    r_refr <= i_cfg_data[REFR_W-1:0];
                end else if (i_cfg_idx == CFG_DECAY) begin
                    r_decay <= i_cfg_data[DECAY_W-1:0];
                end
            end

            if (r_state == S_DONE && (!r_ovalid || !i_stall)) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_x     <= 48'(i_sample) << 24;
                        r_sec   <= '0;
                        r_term  <= '0;
                        r_ph    <= '0;
                        r_state <= S_FILT;
                    end
                end
                S_FILT: begin
                    if (r_ph != 2'd2) begin
                        r_ph <= r_ph + 1'b1;
                    end else begin
                        r_ph  <= '0;
                        r_sum <= acc;
                        case (r_term)
                            3'd0: r_y    <= acc_sat;
                            3'd2: r_w[0] <= acc_sat;
                            default: ;
                        endcase
                        if (r_term == 3'd4) begin
                            // section done: rotate the next section's delays into place
                            r_w[0] <= r_w[2];
                            r_w[1] <= r_w[3];
                            r_w[2] <= r_w[4];
                            r_w[3] <= r_w[5];
                            r_w[4] <= r_w[0];
                            r_w[5] <= acc_sat;
                            r_x    <= r_y;
                            r_term <= '0;
                            r_sec  <= r_sec + 1'b1;
                            if (r_sec == 2'd2) begin
                                r_state <= S_CONV;
                            end
                        end else begin
                            r_term <= r_term + 1'b1;
                        end
                    end
                end
                S_CONV: begin
                    r_filt  <= filt_new;
                    r_state <= S_DIFF;
                end
                S_DIFF: begin
                    r_md    <= diff[25] ? 26'(-diff) : 26'(diff);
                    r_prev  <= r_filt;
                    r_ph    <= '0;
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    if (r_ph[0]) begin
                        r_ph    <= '0;
                        r_state <= S_SQR;
                    end else begin
                        r_ph <= r_ph + 1'b1;
                    end
                end
                S_SQR: begin
                    r_sq    <= sq_sat;
                    r_state <= S_WIN;
                end
                S_WIN: begin
                    r_total         <= total_new;
                    r_wvalid[r_pos] <= 1'b1;
                    r_pos <= (32'(r_pos) >= WINDOW - 1) ? '0 : r_pos + 1'b1;
                    r_dq    <= total_new;
                    r_rem   <= '0;
                    r_cnt   <= 1'b0;
                    r_ph    <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_ph != 2'd2) begin
                        r_ph <= r_ph + 1'b1;
                    end else begin
                        r_ph <= '0;
                        if (!r_cnt) begin
                            r_rem                <= div_r[5:0];
                            r_mean[VAL_W-1:23]   <= div_q[VAL_W-24:0];
                            r_cnt                <= 1'b1;
                        end else begin
                            r_mean[22:0] <= div_q;
                            r_state      <= S_DET;
                        end
                    end
                end
                S_DET: begin
                    r_thr_out <= r_thr;
                    r_beat    <= det_beat;
                    r_ph      <= '0;
                    if (det_beat) begin
                        r_thr   <= thr_mix[VAL_W-1:0];
                        r_since <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_since <= since_inc;
                        r_state <= allowed ? S_DECAY : S_DONE;
                    end
                end
                S_DECAY: begin
                    if (r_ph == 2'd2) begin
                        r_ph    <= '0;
                        r_thr   <= prod[VAL_W+15:16];
                        r_state <= S_DONE;
                    end else begin
                        r_ph <= r_ph + 1'b1;
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || !i_stall) begin
                        r_o_int  <= r_mean;
                        r_o_thr  <= r_thr_out;
                        r_o_beat <= r_beat;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = r_ovalid;
    assign o_integrated = r_o_int;
    assign o_threshold  = r_o_thr;
    assign o_beat       = r_o_beat;

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input not stalled after transfer");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_pos) < WINDOW)
        else $error("window position out of range");

    a_decay_no_growth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECAY && r_ph == 2'd2) |=> r_thr <= $past(r_thr))
        else $error("threshold grew under decay");

    a_beat_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DET && det_beat) |=> (r_since == '0 && r_beat))
        else $error("beat did not clear refractory count");

    a_section_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILT) |-> (r_sec != 2'd3 && r_term <= 3'd4))
        else $error("filter sequencer out of range");
endmodule

// ----- test/tb_qrs_beat_detector.sv -----
// self-checking testbench for the qrs beat detector with a built-in predictor
module tb_qrs_beat_detector;
    timeunit 1ns;
    timeprecision 1ps;
    import qrs_pkg::*;

    localparam int WIN     = DEF_WINDOW;
    localparam int SBITS   = DEF_SAMPLE_BITS;
    localparam int LATENCY = 80;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [VAL_W-1:0] integrated;
        logic [VAL_W-1:0] threshold;
        logic             beat;
    } t_beat_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [SBITS-1:0]     i_sample;
    logic                 o_valid;
    logic                 i_stall;
    logic [VAL_W-1:0]     o_integrated;
    logic [VAL_W-1:0]     o_threshold;
    logic                 o_beat;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    qrs_beat_detector dut (.*);

    // predictor state
    longint            bq_delay[6];
    longint            prev_filt;
    longint unsigned   win_store[WIN];
    int                win_pos;
    longint unsigned   win_total;
    longint unsigned   cur_threshold;
    int unsigned       since_beat;
    int unsigned       refractory;
    int unsigned       decay;

    logic [SBITS-1:0]  sample_queue[$];
    t_beat_result      expected_results[$];
    int                mismatches;
    int                watchdog;
    bit                quiet_phase;
    bit                hold_sender;
    int                send_gap;
    int                recv_gap;

    // filter coefficients per section: b0, b1, b2, a1, a2 in Q3.29
    const longint bq_coef[3][5] = '{
        '{841282, 1682565, 841282, -930699517, 416439766},
        '{536870912, 0, -536870912, -922129972, 447683923},
        '{536870912, -1073741824, 536870912, -1029195164, 501420100}
    };

    function automatic longint clamp48(longint v);
        longint hi;
        hi = 64'sh7FFF_FFFF_FFFF;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    // q3.29 by q24.24, rounded half away from zero
    function automatic longint coef_mul(longint c, longint v);
        bit              neg;
        longint unsigned mc, mv, p, q, r;
        neg = (c < 0) != (v < 0);
        mc = c < 0 ? -c : c;
        mv = v < 0 ? -v : v;
        p = mc * (mv >> 24);
        q = mc * (mv & 64'hFF_FFFF);
        r = (p >> 5) + ((((p & 31) << 24) + q + (64'd1 << 28)) >> 29);
        return neg ? -longint'(r) : longint'(r);
    endfunction

    function automatic void predictor_reset();
        foreach (bq_delay[i]) bq_delay[i] = 0;
        foreach (win_store[i]) win_store[i] = 0;
        prev_filt = 0;
        win_pos = 0;
        win_total = 0;
        cur_threshold = THRESH_RESET;
        since_beat = 0;
        refractory = REFR_RESET;
        decay = DECAY_RESET;
    endfunction

    function automatic t_beat_result predict_beat(logic [SBITS-1:0] smp);
        t_beat_result    res;
        longint          x, y, filt, d;
        longint unsigned mag, sq, mean;
        x = longint'(smp) << 24;
        for (int s = 0; s < 3; s++) begin
            y = clamp48(coef_mul(bq_coef[s][0], x) + bq_delay[2*s]);
            bq_delay[2*s] = clamp48(coef_mul(bq_coef[s][1], x)
                - coef_mul(bq_coef[s][3], y) + bq_delay[2*s+1]);
            bq_delay[2*s+1] = clamp48(coef_mul(bq_coef[s][2], x)
                - coef_mul(bq_coef[s][4], y));
            x = y;
        end
        mag = x < 0 ? -x : x;
        mag = (mag + 64'h8000) >> 16;
        filt = x < 0 ? -longint'(mag) : longint'(mag);
        if (filt > 64'shFF_FFFF) filt = 64'shFF_FFFF;
        if (filt < -64'sh100_0000) filt = -64'sh100_0000;
        d = filt - prev_filt;
        prev_filt = filt;
        mag = d < 0 ? -d : d;
        sq = (mag * mag + 128) >> 8;
        if (sq > 64'hFF_FFFF_FFFF) sq = 64'hFF_FFFF_FFFF;
        win_total = win_total - win_store[win_pos] + sq;
        win_store[win_pos] = sq;
        win_pos = (win_pos + 1) % WIN;
        mean = win_total / WIN;
        res.integrated = mean[VAL_W-1:0];
        res.threshold = cur_threshold[VAL_W-1:0];
        res.beat = 1'b0;
        if (since_beat < 1023) since_beat++;
        if (since_beat >= refractory) begin
            if (mean > cur_threshold) begin
                res.beat = 1'b1;
                cur_threshold = ((mean + 7 * cur_threshold) >> 3) & 64'hFF_FFFF_FFFF;
                since_beat = 0;
            end else begin
                cur_threshold = (cur_threshold * decay) >> 16;
            end
        end
        return res;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_gap <= 0;
        end else if (!i_valid || !o_stall) begin
            if (i_valid) expected_results.push_back(predict_beat(i_sample));
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                i_valid <= 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
                send_gap <= $urandom_range(0, 17);
                i_valid <= 1'b0;
            end else if (sample_queue.size() > 0 && !hold_sender) begin
                i_valid <= 1'b1;
                i_sample <= sample_queue.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor and receiver stall
    always @(posedge i_clk) begin
        t_beat_result got, exp_res;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                got = '{o_integrated, o_threshold, o_beat};
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected transfer %p", got);
                end else begin
                    exp_res = expected_results.pop_front();
                    if (got !== exp_res) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p, got %p", exp_res, got);
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                i_stall <= 1'b1;
            end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
                recv_gap <= $urandom_range(0, 17);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            watchdog <= 0;
        end else begin
            watchdog <= watchdog + 1;
            if (watchdog >= WATCHDOG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (sample_queue.size() > 0 || i_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_REFRACTORY) refractory = val & 16'h3FF;
        else if (idx == CFG_DECAY) decay = val;
    endtask

    // heartbeat-like waveform: flat baseline with sharp spikes
    task automatic push_ecg(int count, int period, int amp);
        int base;
        base = $urandom_range(1000, 3000);
        for (int i = 0; i < count; i++) begin
            if (i % period < 3) sample_queue.push_back(SBITS'(base + amp - (i % period) * 50));
            else sample_queue.push_back(SBITS'(base + $urandom_range(0, 40)));
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_sample = '0;
        i_stall = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        mismatches = 0;
        watchdog = 0;
        quiet_phase = 1'b0;
        hold_sender = 1'b1;
        predictor_reset();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes and alternating full-scale steps
        sample_queue = '{12'h000, 12'hFFF, 12'h000, 12'hFFF, 12'hAAA, 12'h555, 12'hFFF,
                         12'hFFF, 12'h000, 12'h000, 12'h800, 12'h7FF, 12'hFFF, 12'h000};
        for (int i = 0; i < 8; i++) sample_queue.push_back(i[0] ? 12'hFFF : 12'h000);
        hold_sender = 1'b0;
        wait_drained();

        // zero refractory, decay factor zero, bogus register index
        write_reg(CFG_REFRACTORY, 16'hFC00);
        write_reg(CFG_DECAY, 16'd0);
        write_reg(2'd3, 16'hFFFF);
        push_ecg(150, 25, 1500);
        for (int i = 0; i < 50; i++) sample_queue.push_back(SBITS'($urandom));
        wait_drained();

        // maximum refractory and decay
        write_reg(CFG_REFRACTORY, 16'd1023);
        write_reg(CFG_DECAY, 16'hFFFF);
        push_ecg(150, 60, 2000);
        wait_drained();

        // typical settings with random values
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(CFG_REFRACTORY, CFG_W'($urandom_range(0, 80)));
            write_reg(CFG_DECAY, CFG_W'($urandom_range(60000, 65535)));
            if (ph == 3) quiet_phase = 1'b1;
            push_ecg(120, $urandom_range(20, 70), $urandom_range(200, 1000));
            for (int i = 0; i < 30; i++) sample_queue.push_back(SBITS'($urandom));
            wait_drained();
        end

        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- qrs_beat_detector.f -----
rtl/core/qrs_pkg.sv
rtl/core/qrs_ram.sv
rtl/core/qrs_mul.sv
rtl/core/qrs_beat_detector.sv
test/tb_qrs_beat_detector.sv
